[src/bsp_pkg.sv]
// bsp_pkg: shared types and constants for the bounding sphere core
// no dependencies; used by every other file in src except bsp_if and bsp_checker

package bsp_pkg;

	localparam int COORD_W   = 16;
	localparam int CENTER_W  = 17;
	localparam int RADIUS_W  = 15;
	localparam int PROD_W    = 33;
	localparam int SQ_W      = 32;
	localparam int SUM_W     = 34;
	localparam int ROOT_W    = 17;
	localparam int REM_W     = 18;
	localparam int ROOT_STEPS = 17;
	localparam int STEP_W    = 5;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_SCALE_X  = 3'd0;
	localparam reg_idx_t REG_SCALE_Y  = 3'd1;
	localparam reg_idx_t REG_SCALE_Z  = 3'd2;
	localparam reg_idx_t REG_OFFSET_X = 3'd3;
	localparam reg_idx_t REG_OFFSET_Y = 3'd4;
	localparam reg_idx_t REG_OFFSET_Z = 3'd5;

	localparam logic [COORD_W-1:0] SCALE_RESET  = 16'd256;
	localparam logic [COORD_W-1:0] OFFSET_RESET = 16'd0;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] scale;
		logic [2:0][COORD_W-1:0] offset;
	} cfg_t;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] lo;
		logic [2:0][COORD_W-1:0] hi;
	} box_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SQUARE,
		BK_SUM,
		BK_ROOT,
		BK_OUT
	} back_state_t;

endpackage

[src/bsp_if.sv]
// bsp_if: valid/ready channel interfaces for points in and spheres out
// depends on nothing; instantiated around bounding_sphere_from_points_core

interface bsp_point_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic signed [15:0] point_z;
	logic               last_point;

	modport source (output valid, point_x, point_y, point_z, last_point, input ready);
	modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface bsp_sphere_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] center_x;
	logic signed [16:0] center_y;
	logic signed [16:0] center_z;
	logic        [14:0] radius;

	modport source (output valid, center_x, center_y, center_z, radius, input ready);
	modport sink   (input valid, center_x, center_y, center_z, radius, output ready);
endinterface

[src/bounding_sphere_from_points_core.sv]
// bounding_sphere_from_points_core: top level of the bounding sphere core
// depends on bsp_pkg, bsp_if, bsp_regs, bsp_front, bsp_queue, bsp_back
//
// points arrive on the point channel, one per cycle when ready, each with a
// last_point flag closing a set. every point is scaled per axis and folded
// into a running box that always holds the origin; points that do not close
// a set produce nothing. the transfer carrying last_point yields one sphere
// on the sphere channel: centre per axis plus configured offset, and a
// quarter of the box diagonal as radius.
// throughput: one point per cycle while the queue has room. a closed box
// passes a two-entry queue to the back end, which works on one set at a
// time (pop and centre, squares, sum, a 17-step square root with one result
// bit per cycle, and the load into the output register) and takes the next
// box only after that load. a stalled sphere sink holds the output register
// and the back end then waits. short sets or such a wait stall the point
// channel on a last point once the queue is full. reset clears the box, the
// queue and the output; scales go to 1.0 and offsets to 0. the apb port is
// always ready and not guarded: the user must write it only while idle.

module bounding_sphere_from_points_core import bsp_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	bsp_point_if.sink             point,
	bsp_sphere_if.source          sphere
);

	cfg_t cfg;
	logic push_valid;
	logic push_ready;
	box_t push_box;
	logic pop_valid;
	logic pop_ready;
	box_t pop_box;

	bsp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.point      (point),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_box   (push_box)
	);

	bsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_box   (push_box),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_box    (pop_box)
	);

	bsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_box   (pop_box),
		.sphere    (sphere)
	);

endmodule

[src/bsp_regs.sv]
// bsp_regs: apb register file holding axis scales and offsets
// depends on bsp_pkg

module bsp_regs import bsp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale  <= {3{SCALE_RESET}};
			cfg_q.offset <= {3{OFFSET_RESET}};
		end else if (wr_en) begin
			case (idx)
				REG_SCALE_X:  cfg_q.scale[0]  <= pwdata[COORD_W-1:0];
				REG_SCALE_Y:  cfg_q.scale[1]  <= pwdata[COORD_W-1:0];
				REG_SCALE_Z:  cfg_q.scale[2]  <= pwdata[COORD_W-1:0];
				REG_OFFSET_X: cfg_q.offset[0] <= pwdata[COORD_W-1:0];
				REG_OFFSET_Y: cfg_q.offset[1] <= pwdata[COORD_W-1:0];
				REG_OFFSET_Z: cfg_q.offset[2] <= pwdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_SCALE_X:  prdata[COORD_W-1:0] = cfg_q.scale[0];
			REG_SCALE_Y:  prdata[COORD_W-1:0] = cfg_q.scale[1];
			REG_SCALE_Z:  prdata[COORD_W-1:0] = cfg_q.scale[2];
			REG_OFFSET_X: prdata[COORD_W-1:0] = cfg_q.offset[0];
			REG_OFFSET_Y: prdata[COORD_W-1:0] = cfg_q.offset[1];
			REG_OFFSET_Z: prdata[COORD_W-1:0] = cfg_q.offset[2];
			default:      prdata = '0;
		endcase
	end

endmodule

[src/bsp_front.sv]
// bsp_front: point intake, per-axis scaling and running box tracking
// depends on bsp_pkg and bsp_point_if; hands finished boxes to bsp_queue

module bsp_front import bsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	bsp_point_if.sink  point,
	output logic       push_valid,
	input  logic       push_ready,
	output box_t       push_box
);

	logic                     valid_s1;
	logic                     last_s1;
	logic signed [PROD_W-1:0] prod_s1 [3];
	coord_t                   lo_q [3];
	coord_t                   hi_q [3];
	coord_t                   pt [3];
	coord_t                   val [3];
	coord_t                   new_lo [3];
	coord_t                   new_hi [3];
	logic signed [24:0]       shifted [3];
	logic                     advance_s1;
	logic                     take;

	assign pt[0] = point.point_x;
	assign pt[1] = point.point_y;
	assign pt[2] = point.point_z;

	// a last point waits in stage one until the queue has room
	assign advance_s1  = !last_s1 || push_ready;
	assign point.ready = !valid_s1 || advance_s1;
	assign take        = point.valid && point.ready;
	assign push_valid  = valid_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (point.ready) begin
			valid_s1 <= point.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			last_s1 <= point.last_point;
			for (int a = 0; a < 3; a++) begin
				prod_s1[a] <= $signed(pt[a]) * $signed({1'b0, cfg.scale[a]});
			end
		end
	end

	// floor shift by eight then saturate, then fold into the box
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			shifted[a] = prod_s1[a][PROD_W-1:8];
			if ((&shifted[a][24:15]) || !(|shifted[a][24:15])) begin
				val[a] = shifted[a][15:0];
			end else if (shifted[a][24]) begin
				val[a] = 16'sh8000;
			end else begin
				val[a] = 16'sh7fff;
			end
			new_lo[a] = (val[a] < lo_q[a]) ? val[a] : lo_q[a];
			new_hi[a] = (val[a] > hi_q[a]) ? val[a] : hi_q[a];
			push_box.lo[a] = new_lo[a];
			push_box.hi[a] = new_hi[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				lo_q[a] <= '0;
				hi_q[a] <= '0;
			end
		end else if (valid_s1 && advance_s1) begin
			for (int a = 0; a < 3; a++) begin
				lo_q[a] <= last_s1 ? '0 : new_lo[a];
				hi_q[a] <= last_s1 ? '0 : new_hi[a];
			end
		end
	end

endmodule

[src/bsp_queue.sv]
// bsp_queue: short fifo of finished boxes between front and back
// depends on bsp_pkg

module bsp_queue import bsp_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  box_t push_box,
	output logic pop_valid,
	input  logic pop_ready,
	output box_t pop_box
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	box_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_box    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_box;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/bsp_back.sv]
// bsp_back: centre, squared diagonal and iterative square root per box
// depends on bsp_pkg and bsp_sphere_if; drains bsp_queue

module bsp_back import bsp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  box_t          pop_box,
	bsp_sphere_if.source  sphere
);

	back_state_t                state_q;
	back_state_t                state_d;
	logic signed [CENTER_W-1:0] cen_q [3];
	logic [COORD_W-1:0]         ext_q [3];
	logic [SQ_W-1:0]            sq_q [3];
	logic [SUM_W-1:0]           n_q;
	logic [REM_W-1:0]           rem_q;
	logic [ROOT_W-1:0]          root_q;
	logic [STEP_W-1:0]          step_q;
	logic                       out_valid_q;
	logic signed [CENTER_W-1:0] out_cen_q [3];
	logic [RADIUS_W-1:0]        out_rad_q;

	logic                       load_out;
	logic                       root_last;
	logic signed [CENTER_W-1:0] pair_sum [3];
	logic signed [CENTER_W-1:0] diff [3];
	logic signed [CENTER_W-1:0] cen_d [3];
	logic [REM_W+1:0]           rem_sh;
	logic [REM_W+1:0]           trial;
	logic                       fits;

	assign root_last = step_q == STEP_W'(ROOT_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) state_d = BK_SQUARE;
			end
			BK_SQUARE: state_d = BK_SUM;
			BK_SUM:    state_d = BK_ROOT;
			BK_ROOT: begin
				if (root_last) state_d = BK_OUT;
			end
			BK_OUT: begin
				if (!out_valid_q || sphere.ready) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			pair_sum[a] = $signed({pop_box.lo[a][COORD_W-1], pop_box.lo[a]})
				+ $signed({pop_box.hi[a][COORD_W-1], pop_box.hi[a]});
			diff[a] = $signed({pop_box.hi[a][COORD_W-1], pop_box.hi[a]})
				- $signed({pop_box.lo[a][COORD_W-1], pop_box.lo[a]});
			cen_d[a] = $signed({pair_sum[a][CENTER_W-1], pair_sum[a][CENTER_W-1:1]})
				+ $signed({cfg.offset[a][COORD_W-1], cfg.offset[a]});
		end
		rem_sh = {rem_q, n_q[SUM_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		fits   = rem_sh >= trial;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				for (int a = 0; a < 3; a++) begin
					cen_q[a] <= cen_d[a];
					ext_q[a] <= diff[a][COORD_W-1:0];
				end
			end
			BK_SQUARE: begin
				for (int a = 0; a < 3; a++) begin
					sq_q[a] <= ext_q[a] * ext_q[a];
				end
			end
			BK_SUM: begin
				n_q    <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
				rem_q  <= '0;
				root_q <= '0;
				step_q <= '0;
			end
			BK_ROOT: begin
				n_q    <= {n_q[SUM_W-3:0], 2'b00};
				step_q <= step_q + 1'b1;
				if (fits) begin
					rem_q  <= REM_W'(rem_sh - trial);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh[REM_W-1:0];
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (sphere.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			for (int a = 0; a < 3; a++) begin
				out_cen_q[a] <= cen_q[a];
			end
			out_rad_q <= root_q[ROOT_W-1:2];
		end
	end

	assign sphere.valid    = out_valid_q;
	assign sphere.center_x = out_cen_q[0];
	assign sphere.center_y = out_cen_q[1];
	assign sphere.center_z = out_cen_q[2];
	assign sphere.radius   = out_rad_q;

endmodule

[src/bsp_checker.sv]
// bsp_checker: port-level checks on the sphere channel of the core
// depends on the top level's ports only; attached by the bind below

module bsp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [16:0] cx,
	input logic signed [16:0] cy,
	input logic signed [16:0] cz,
	input logic [14:0]       radius
);

	// no sphere is offered while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("sphere valid during reset");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("sphere valid dropped without transfer");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(cx) && $stable(cy) && $stable(cz)
			&& $stable(radius))
		else $error("sphere payload changed while stalled");

	// one above the largest radius, the floored quarter of the largest box diagonal
	a_radius_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> radius <= 15'd28378)
		else $error("sphere radius out of range");

endmodule

bind bounding_sphere_from_points_core bsp_checker u_bsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (sphere.valid),
	.out_ready (sphere.ready),
	.cx        (sphere.center_x),
	.cy        (sphere.center_y),
	.cz        (sphere.center_z),
	.radius    (sphere.radius)
);

[verif/tb_bounding_sphere_from_points_core.sv]
`timescale 1ns / 100ps
// testbench for bounding_sphere_from_points_core: point sets are streamed in and every
// sphere is checked against an in-bench prediction, across several register settings
// depends on bsp_pkg, bsp_if and the core sources in src

module tb_bounding_sphere_from_points_core;
	import bsp_pkg::*;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int NUM_REGS      = 6;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_ITEMS   = 230;

	typedef struct packed {
		logic signed [CENTER_W-1:0] centre_x;
		logic signed [CENTER_W-1:0] centre_y;
		logic signed [CENTER_W-1:0] centre_z;
		logic        [RADIUS_W-1:0] radius;
	} sphere_t;

	class sphere_tracker;
		logic [COORD_W-1:0] scale [3];
		coord_t             offset [3];
		int                 box_lo [3];
		int                 box_hi [3];
		sphere_t            pending_spheres [$];
		int                 errors;

		function new();
			for (int a = 0; a < 3; a++) begin
				scale[a]  = SCALE_RESET;
				offset[a] = OFFSET_RESET;
				box_lo[a] = 0;
				box_hi[a] = 0;
			end
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] data);
			case (idx)
				REG_SCALE_X:  scale[0]  = data[COORD_W-1:0];
				REG_SCALE_Y:  scale[1]  = data[COORD_W-1:0];
				REG_SCALE_Z:  scale[2]  = data[COORD_W-1:0];
				REG_OFFSET_X: offset[0] = data[COORD_W-1:0];
				REG_OFFSET_Y: offset[1] = data[COORD_W-1:0];
				REG_OFFSET_Z: offset[2] = data[COORD_W-1:0];
				default: ;
			endcase
		endfunction

		function void check_reg(reg_idx_t idx, logic [COORD_W-1:0] got);
			logic [COORD_W-1:0] want;
			case (idx)
				REG_SCALE_X:  want = scale[0];
				REG_SCALE_Y:  want = scale[1];
				REG_SCALE_Z:  want = scale[2];
				REG_OFFSET_X: want = offset[0];
				REG_OFFSET_Y: want = offset[1];
				default:      want = offset[2];
			endcase
			if (got !== want) begin
				errors++;
				$display("%0t: register %0d expected %h, got %h", $time, idx, want, got);
			end
		endfunction

		function int scaled(coord_t p, logic [COORD_W-1:0] s);
			longint prod;
			prod = (longint'(p) * longint'(s)) >>> 8;
			if (prod > 32767)
				prod = 32767;
			if (prod < -32768)
				prod = -32768;
			return int'(prod);
		endfunction

		function longint unsigned root_floor(longint unsigned n);
			longint unsigned res;
			longint unsigned one_bit;
			res = 0;
			one_bit = 64'd1 << 62;
			while (one_bit > n)
				one_bit >>= 2;
			while (one_bit != 0) begin
				if (n >= res + one_bit) begin
					n -= res + one_bit;
					res = (res >> 1) + one_bit;
				end else begin
					res >>= 1;
				end
				one_bit >>= 2;
			end
			return res;
		endfunction

		function void note_point(coord_t px, coord_t py, coord_t pz, logic last);
			coord_t          p [3];
			int              v;
			longint          ext;
			longint          ctr [3];
			longint unsigned sq_sum;
			sphere_t         s;
			p[0] = px;
			p[1] = py;
			p[2] = pz;
			for (int a = 0; a < 3; a++) begin
				v = scaled(p[a], scale[a]);
				if (v > box_hi[a])
					box_hi[a] = v;
				else if (v < box_lo[a])
					box_lo[a] = v;
			end
			if (!last)
				return;
			sq_sum = 0;
			for (int a = 0; a < 3; a++) begin
				ext = longint'(box_hi[a]) - longint'(box_lo[a]);
				sq_sum += longint'(ext * ext);
				ctr[a] = (longint'(box_lo[a]) + longint'(box_hi[a]) + 2 * longint'(offset[a])) >>> 1;
				box_lo[a] = 0;
				box_hi[a] = 0;
			end
			s.centre_x = ctr[0][CENTER_W-1:0];
			s.centre_y = ctr[1][CENTER_W-1:0];
			s.centre_z = ctr[2][CENTER_W-1:0];
			s.radius   = RADIUS_W'(root_floor(sq_sum) >> 2);
			pending_spheres.push_back(s);
		endfunction

		function void compare_field(string name, logic signed [63:0] want,
				logic signed [63:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_sphere(sphere_t got);
			sphere_t want;
			if (pending_spheres.size() == 0) begin
				errors++;
				$display("%0t: sphere with none expected: centre (%0d,%0d,%0d) radius %0d",
					$time, got.centre_x, got.centre_y, got.centre_z, got.radius);
				return;
			end
			want = pending_spheres.pop_front();
			compare_field("centre_x", want.centre_x, got.centre_x);
			compare_field("centre_y", want.centre_y, got.centre_y);
			compare_field("centre_z", want.centre_z, got.centre_z);
			compare_field("radius", want.radius, got.radius);
		endfunction

		function int pending();
			return pending_spheres.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	bit source_calm = 1'b0;
	bit sink_calm = 1'b0;
	bit hold_request = 1'b0;
	int cycle_count = 0;

	sphere_tracker spheres = new();

	bsp_point_if  point_ch();
	bsp_sphere_if sphere_ch();

	bounding_sphere_from_points_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.point   (point_ch),
		.sphere  (sphere_ch)
	);

	always #5 clk = ~clk;

	function automatic int draw_wait(bit calm);
		if (calm || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 10);
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 5))
			0:       return 16'sh7fff;
			1:       return 16'sh8000;
			2:       return coord_t'($urandom_range(0, 511) - 256);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] rand_scale();
		case ($urandom_range(0, 4))
			0:       return SCALE_RESET;
			1:       return COORD_W'($urandom_range(0, 511));
			2:       return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	task automatic send_point(coord_t px, coord_t py, coord_t pz, logic last);
		int gap;
		gap = draw_wait(source_calm);
		if (gap > 0) begin
			point_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		point_ch.valid      <= 1'b1;
		point_ch.point_x    <= px;
		point_ch.point_y    <= py;
		point_ch.point_z    <= pz;
		point_ch.last_point <= last;
		do @(posedge clk); while (!point_ch.ready);
		spheres.note_point(px, py, pz, last);
		@(negedge clk);
	endtask

	task automatic settle();
		point_ch.valid <= 1'b0;
		while (spheres.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_cycle(reg_idx_t idx, logic write, logic [APB_DATA_W-1:0] wdata,
			output logic [APB_DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		if (write)
			spheres.write_reg(idx, wdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_settings(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
			logic [COORD_W-1:0] sz, logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy,
			logic [COORD_W-1:0] oz);
		logic [COORD_W-1:0]    vals [NUM_REGS];
		logic [APB_DATA_W-1:0] rd;
		vals = '{sx, sy, sz, ox, oy, oz};
		for (int i = 0; i < NUM_REGS; i++)
			apb_cycle(reg_idx_t'(i), 1'b1, {16'($urandom), vals[i]}, rd);
		// unmapped slots must be ignored
		if ($urandom_range(0, 1))
			apb_cycle(reg_idx_t'($urandom_range(NUM_REGS, 7)), 1'b1, $urandom, rd);
		for (int i = 0; i < NUM_REGS; i++) begin
			apb_cycle(reg_idx_t'(i), 1'b0, '0, rd);
			spheres.check_reg(reg_idx_t'(i), rd[COORD_W-1:0]);
		end
	endtask

	task automatic run_sets(int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
			for (int k = 1; k <= len; k++)
				send_point(rand_coord(), rand_coord(), rand_coord(), k == len);
			sent += len;
		end
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int      stall;
		sphere_t got;
		sphere_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				stall = HOLD_CYCLES;
				hold_request = 1'b0;
			end else begin
				stall = draw_wait(sink_calm);
			end
			if (stall > 0) begin
				sphere_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			sphere_ch.ready <= 1'b1;
			do @(posedge clk); while (!sphere_ch.valid);
			got.centre_x = sphere_ch.center_x;
			got.centre_y = sphere_ch.center_y;
			got.centre_z = sphere_ch.center_z;
			got.radius   = sphere_ch.radius;
			spheres.check_sphere(got);
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		point_ch.valid      = 1'b0;
		point_ch.point_x    = '0;
		point_ch.point_y    = '0;
		point_ch.point_z    = '0;
		point_ch.last_point = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: origin only, extremes, multi-point set
		send_point(16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
		send_point(16'sh7fff, 16'sh8000, -16'sd1, 1'b1);
		send_point(16'sh8000, 16'sh7fff, 16'sd1, 1'b0);
		send_point(16'sh7fff, 16'sh8000, 16'sh8000, 1'b0);
		send_point(16'sd5, -16'sd5, 16'sd100, 1'b1);
		settle();

		// largest scale: saturation both ways, largest radius
		load_settings(16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
		send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
		send_point(16'sd1, -16'sd1, 16'sd0, 1'b1);
		send_point(16'sh8000, 16'sh7fff, 16'sd2, 1'b1);
		settle();

		// zero scale collapses the box to the origin
		load_settings(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
		send_point(16'sh7fff, 16'sh8000, 16'sd12345, 1'b1);
		send_point(-16'sd1, 16'sd1, 16'sd0, 1'b0);
		send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
		settle();

		// fractional scales: flooring of negative products
		load_settings(16'h0180, 16'h00ff, 16'h0001, 16'h1234, 16'hedcb, 16'h0001);
		send_point(-16'sd1, -16'sd1, -16'sd1, 1'b1);
		send_point(16'sd3, -16'sd3, 16'sd7, 1'b0);
		send_point(16'sh8000, 16'sh7fff, -16'sd5, 1'b1);
		send_point(16'sd255, -16'sd255, 16'sd300, 1'b1);
		settle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			load_settings(rand_scale(), rand_scale(), rand_scale(),
				16'($urandom), 16'($urandom), 16'($urandom));
			source_calm = ($urandom_range(0, 3) == 0);
			sink_calm   = ($urandom_range(0, 3) == 0);
			if (ph == 2) begin
				// back-to-back single-point sets against a held-off sink
				hold_request = 1'b1;
				source_calm  = 1'b1;
				for (int k = 0; k < 30; k++)
					send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
				source_calm = 1'b0;
			end
			run_sets(PHASE_ITEMS);
			settle();
		end

		if (spheres.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
